// ===== hdl/c2d_pkg.sv =====
// shared constants, types and helpers for the 3x3 valid convolution stream
package c2d_pkg;

  localparam int IMG_SIZE  = 64;
  localparam int ADDR_W    = $clog2(IMG_SIZE);
  localparam int PIX_W     = 16;
  localparam int COEF_W    = 16;
  localparam int KREG_W    = 3 * COEF_W;
  localparam int PROD_W    = PIX_W + COEF_W;
  localparam int ROW_W     = PROD_W + 2;
  localparam int SUM_W     = 36;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] KREG_TOP    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] KREG_MID    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] KREG_BOTTOM = CFG_IDX_W'(2);

  typedef logic signed [PIX_W-1:0] pix_t;

  // [row][col], col 2 is the newest column
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef logic [2:0][KREG_W-1:0] kern_t;

  typedef struct packed {
    logic emit;
    logic row_end;
    logic image_end;
  } tag_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] conv_sum;
    logic                    row_end;
    logic                    image_end;
  } res_t;

  function automatic logic signed [COEF_W-1:0] coef(input logic [KREG_W-1:0] krow,
                                                    input int col);
    return krow[col*COEF_W +: COEF_W];
  endfunction

endpackage

// ===== hdl/c2d_if.sv =====
// stream interfaces for pixel items and result items
interface c2d_pix_if import c2d_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface c2d_res_if import c2d_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] conv_sum;
  logic                    row_end;
  logic                    image_end;

  modport source (output valid, output conv_sum, output row_end, output image_end,
                  input ready);
  modport sink (input valid, input conv_sum, input row_end, input image_end,
                output ready);
endinterface

// ===== hdl/c2d_linebuf.sv =====
// line buffer memory, raster counters and 3x3 window registers
module c2d_linebuf import c2d_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic acc_i,
  input  pix_t pixel_i,
  output win_t win_o,
  output tag_t tag_o,
  output logic valid_o
);

  logic [ADDR_W-1:0] col_q, col_d;
  logic [ADDR_W-1:0] row_q, row_d;
  logic              col_last, row_last;
  tag_t              tag_d;

  logic [2*PIX_W-1:0] mem_q [IMG_SIZE];
  logic [2*PIX_W-1:0] rd_q;

  logic              s1_valid_q;
  pix_t              s1_pixel_q;
  logic [ADDR_W-1:0] s1_addr_q;
  tag_t              s1_tag_q;

  pix_t win_q [3][2];
  pix_t col_new [3];
  logic wr_en;

  assign col_last = (col_q == ADDR_W'(IMG_SIZE - 1));
  assign row_last = (row_q == ADDR_W'(IMG_SIZE - 1));

  always_comb begin
    col_d = col_q + ADDR_W'(1);
    row_d = row_q;
    if (col_last) begin
      col_d = '0;
      row_d = row_last ? '0 : row_q + ADDR_W'(1);
    end
    tag_d.emit      = (row_q >= ADDR_W'(2)) && (col_q >= ADDR_W'(2));
    tag_d.row_end   = col_last;
    tag_d.image_end = col_last && row_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // older row in the upper half, newer row in the lower half
  assign wr_en = en_i && s1_valid_q;

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      rd_q <= mem_q[col_q];
    end
    if (wr_en) begin
      mem_q[s1_addr_q] <= {rd_q[PIX_W-1:0], s1_pixel_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= acc_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_pixel_q <= pixel_i;
      s1_addr_q  <= col_q;
      s1_tag_q   <= tag_d;
    end
  end

  assign col_new[0] = rd_q[2*PIX_W-1:PIX_W];
  assign col_new[1] = rd_q[PIX_W-1:0];
  assign col_new[2] = s1_pixel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= '0;
        win_q[i][1] <= '0;
      end
    end else if (wr_en) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= col_new[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_o[i][0] = win_q[i][0];
      win_o[i][1] = win_q[i][1];
      win_o[i][2] = col_new[i];
    end
  end

  assign tag_o   = s1_tag_q;
  assign valid_o = s1_valid_q && s1_tag_q.emit;

  // write-back never hits the entry being read in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && acc_i) |-> (s1_addr_q != col_q))
    else $error("line buffer read and write to the same column");

  // a stalled item in the read stage stays there
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !en_i) |=> (s1_valid_q && $stable(s1_addr_q)))
    else $error("read stage item lost during stall");

endmodule

// ===== hdl/c2d_mac.sv =====
// nine parallel multipliers and an adder tree with registered row sums and a combinational final sum
module c2d_mac import c2d_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  win_t  win_i,
  input  tag_t  tag_i,
  input  kern_t kern_i,
  output res_t  res_o,
  output logic  valid_o
);

  logic signed [PROD_W-1:0] prod_q [3][3];
  logic signed [ROW_W-1:0]  row_sum_q [3];
  logic                     a_valid_q, b_valid_q;
  tag_t                     a_tag_q, b_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[i][j] <= $signed(win_i[i][j]) * coef(kern_i[i], j);
        end
      end
      a_tag_q <= tag_i;
    end
    if (en_i && a_valid_q) begin
      for (int i = 0; i < 3; i++) begin
        row_sum_q[i] <= ROW_W'(prod_q[i][0]) + ROW_W'(prod_q[i][1])
                      + ROW_W'(prod_q[i][2]);
      end
      b_tag_q <= a_tag_q;
    end
  end

  always_comb begin
    res_o.conv_sum  = SUM_W'(row_sum_q[0]) + SUM_W'(row_sum_q[1]) + SUM_W'(row_sum_q[2]);
    res_o.row_end   = b_tag_q.row_end;
    res_o.image_end = b_tag_q.image_end;
  end

  assign valid_o = b_valid_q;

endmodule

// ===== hdl/c2d_skid.sv =====
// output register with skid stage
module c2d_skid import c2d_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic full_o,
  c2d_res_if.source res_o
);

  logic out_valid_q, sk_valid_q;
  res_t out_q, sk_q;
  logic pop;

  assign pop = out_valid_q && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sk_valid_q  <= 1'b0;
    end else begin
      if (pop) begin
        if (sk_valid_q) begin
          sk_valid_q <= 1'b0;
        end else begin
          out_valid_q <= push_i;
        end
      end else if (push_i) begin
        if (out_valid_q) begin
          sk_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= sk_valid_q ? sk_q : res_i;
    end else if (push_i) begin
      if (out_valid_q) begin
        sk_q <= res_i;
      end else begin
        out_q <= res_i;
      end
    end
  end

  assign full_o          = sk_valid_q;
  assign res_o.valid     = out_valid_q;
  assign res_o.conv_sum  = out_q.conv_sum;
  assign res_o.row_end   = out_q.row_end;
  assign res_o.image_end = out_q.image_end;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_valid_q |-> out_valid_q)
    else $error("skid entry without output entry");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_valid_q |-> !push_i)
    else $error("item pushed into full output buffer");

endmodule

// ===== hdl/conv2d_3x3_valid_stream.sv =====
// streaming 3x3 valid correlation, top level
// a pixel's result passes the read stage, product, row sum and output registers
// throughput: one pixel per cycle while ready; line buffer read ahead of write-back
// ready drops only while the output skid entry is occupied
// reset clears counters, window registers, kernel registers and pipeline valids
// line buffer memory is not cleared; entries are written before any result uses them
module conv2d_3x3_valid_stream import c2d_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [KREG_W-1:0]    cfg_data_i,
  c2d_pix_if.sink              pix_i,
  c2d_res_if.source            res_o
);

  kern_t kern_q;
  logic  en, acc, full;
  win_t  win;
  tag_t  tag;
  logic  lb_valid, mac_valid;
  res_t  mac_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kern_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        KREG_TOP:    kern_q[0] <= cfg_data_i;
        KREG_MID:    kern_q[1] <= cfg_data_i;
        KREG_BOTTOM: kern_q[2] <= cfg_data_i;
        default:     kern_q    <= kern_q;
      endcase
    end
  end

  assign en          = !full;
  assign pix_i.ready = en;
  assign acc         = pix_i.valid && en;

  c2d_linebuf u_linebuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .acc_i   (acc),
    .pixel_i (pix_i.pixel),
    .win_o   (win),
    .tag_o   (tag),
    .valid_o (lb_valid)
  );

  c2d_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (lb_valid),
    .win_i   (win),
    .tag_i   (tag),
    .kern_i  (kern_q),
    .res_o   (mac_res),
    .valid_o (mac_valid)
  );

  c2d_skid u_skid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (en && mac_valid),
    .res_i  (mac_res),
    .full_o (full),
    .res_o  (res_o)
  );

endmodule
